// ===== hw/rtl/uniform_grid_cell_hash_defines.svh =====
// Assertion macros shared by the grid hash checker.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef UNIFORM_GRID_CELL_HASH_DEFINES_SVH
`define UNIFORM_GRID_CELL_HASH_DEFINES_SVH

// Same-cycle implication.
`define UGCH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grid hash check failed");

// Next-cycle implication.
`define UGCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grid hash check failed");

`endif

// ===== hw/rtl/ugch_pkg.sv =====
// Package for the uniform grid cell hash: types, codes, field widths and the neighbor table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ugch_pkg;

	localparam int POS_W = 32;
	localparam int VAL_W = 20;
	localparam int SLOT_W = 10;
	localparam int CIN_W = 16;
	localparam int RUN_W = 11;
	localparam int CNT_W = 11;
	localparam int KEY_OUT_W = 15;
	localparam int IN_TDATA_W = 176;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int NB_COUNT = 27;
	localparam logic [RUN_W-1:0] RUN_EMPTY = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CNT = 3'd4;

	typedef enum logic [1:0] {
		ACT_MAP   = 2'd0,
		ACT_BUILD = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_READ  = 2'd3
	} act_t;

	// Neighbor offsets plus one, packed {dz, dy, dx}, two bits each.
	localparam logic [5:0] NB_OFS [NB_COUNT] = '{
		6'h00, 6'h01, 6'h02, 6'h04, 6'h05, 6'h06, 6'h08, 6'h09, 6'h0A,
		6'h10, 6'h11, 6'h12, 6'h14, 6'h15, 6'h16, 6'h18, 6'h19, 6'h1A,
		6'h20, 6'h21, 6'h22, 6'h24, 6'h25, 6'h26, 6'h28, 6'h29, 6'h2A
	};

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP_RUN,
		ST_SORT_I,
		ST_SORT_HOLD,
		ST_SORT_J,
		ST_SORT_CMP,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SCAN_END,
		ST_Q_ADDR,
		ST_Q_DATA,
		ST_R_ADDR,
		ST_R_DATA,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		QS_IDLE,
		QS_SUB,
		QS_MUL,
		QS_CHK
	} qstate_t;

	// Status of the quantizer toward the sequencer.
	typedef struct packed {
		logic done;
		logic valid;
	} qstat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ugch_quant.sv =====
// Quantizer: maps a Q16.16 position to a cell key with one shared subtractor and multiplier.
// Depends on ugch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ugch_quant #(
	parameter int GRID_BITS = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ugch_pkg::POS_W-1:0]    pos_x,
	input  wire logic [ugch_pkg::POS_W-1:0]    pos_y,
	input  wire logic [ugch_pkg::POS_W-1:0]    pos_z,
	input  wire logic [ugch_pkg::POS_W-1:0]    org_x,
	input  wire logic [ugch_pkg::POS_W-1:0]    org_y,
	input  wire logic [ugch_pkg::POS_W-1:0]    org_z,
	input  wire logic [ugch_pkg::POS_W-1:0]    inv_cell,
	output ugch_pkg::qstat_t                   stat,
	output logic      [3*GRID_BITS-1:0]        key
);
	import ugch_pkg::*;

	qstate_t              qst_q, qst_nx;
	logic [1:0]           axis_q;
	logic [POS_W:0]       q_q;
	logic [2*POS_W-1:0]   prod_q;
	logic                 ok_q;
	logic                 done_q;
	logic [GRID_BITS-1:0] gx_q, gy_q, gz_q;
	logic [POS_W-1:0]     pos_sel, org_sel;
	logic                 axis_ok;

	// Next state of the per-axis sequence.
	always_comb begin
		qst_nx = qst_q;
		case (qst_q)
			QS_IDLE: if (start) qst_nx = QS_SUB;
			QS_SUB:  qst_nx = QS_MUL;
			QS_MUL:  qst_nx = QS_CHK;
			QS_CHK:  qst_nx = (axis_q == 2'd2) ? QS_IDLE : QS_SUB;
			default: qst_nx = QS_IDLE;
		endcase
	end

	// Operand selection for the current axis and the range check of its cell.
	always_comb begin
		case (axis_q)
			2'd0:    begin pos_sel = pos_x; org_sel = org_x; end
			2'd1:    begin pos_sel = pos_y; org_sel = org_y; end
			default: begin pos_sel = pos_z; org_sel = org_z; end
		endcase
		axis_ok = !q_q[POS_W] && ((prod_q[2*POS_W-1:POS_W] >> GRID_BITS) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qst_q  <= QS_IDLE;
			axis_q <= 2'd0;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
		end else begin
			qst_q  <= qst_nx;
			done_q <= 1'b0;
			case (qst_q)
				QS_IDLE: if (start) begin
					axis_q <= 2'd0;
					ok_q   <= 1'b1;
				end
				QS_CHK: begin
					ok_q <= ok_q & axis_ok;
					if (axis_q == 2'd2) done_q <= 1'b1;
					else axis_q <= axis_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	// Datapath: exact 33-bit difference, then the 32 by 32 product.
	always_ff @(posedge clk) begin
		case (qst_q)
			QS_SUB: q_q <= {pos_sel[POS_W-1], pos_sel} - {org_sel[POS_W-1], org_sel};
			QS_MUL: prod_q <= q_q[POS_W-1:0] * inv_cell;
			QS_CHK: begin
				case (axis_q)
					2'd0:    gx_q <= prod_q[POS_W +: GRID_BITS];
					2'd1:    gy_q <= prod_q[POS_W +: GRID_BITS];
					default: gz_q <= prod_q[POS_W +: GRID_BITS];
				endcase
			end
			default: ;
		endcase
	end

	assign stat.done  = done_q;
	assign stat.valid = ok_q;
	assign key        = ok_q ? {gz_q, gy_q, gx_q} : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/uniform_grid_cell_hash.sv =====
// Top level of the uniform grid cell hash: sequencer, slot table, cell run tables.
// Depends on ugch_pkg and ugch_quant.
//
// One beat is taken at a time and s_tready is high only while the sequencer is idle.
// A map runs the quantizer, which does subtract, multiply and check once per axis on one
// shared multiplier. A read does one registered read of the slot table, and a query one
// of the cell run tables when its cell lies inside the grid. A build sorts the first
// min(entry_count, TABLE_DEPTH) slots by insertion sort, then clears the cell tables at one
// cell a cycle, then scans the sorted slots. After reset the same clearing pass runs before
// the first beat is taken; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module uniform_grid_cell_hash #(
	parameter int GRID_BITS   = 5,
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], item_value[115:96], slot[125:116],
	// cell_x[141:126], cell_y[157:142], cell_z[173:158], zero fill[175:174]
	input  wire logic [ugch_pkg::IN_TDATA_W-1:0]    s_tdata,
	// action[1:0]
	input  wire logic [1:0]                         s_tuser,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// cell_key[14:0], key_valid[15], range_start[26:16], range_finish[37:27],
	// range_found[38], stored_value[58:39], done_res[59], zero fill[63:60]
	output logic      [ugch_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic                               cfg_we,
	input  wire logic [ugch_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ugch_pkg::POS_W-1:0]         cfg_data
);
	import ugch_pkg::*;

	localparam int CELL_W  = 3 * GRID_BITS;
	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int N_W     = IDX_W + 1;
	localparam int ENT_W   = CELL_W + 1;
	localparam int ENTRY_W = VAL_W + ENT_W;
	localparam int CELL_COUNT = 1 << CELL_W;
	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

	// Configuration registers.
	logic [POS_W-1:0] org_x_q, org_y_q, org_z_q, inv_cell_q;
	logic [CNT_W-1:0] entry_cnt_q;

	// Fields of the accepted beat.
	logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [VAL_W-1:0] val_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CIN_W-1:0] cx_in_q, cy_in_q, cz_in_q;

	// Sequencer state and counters.
	state_t             state_q, state_nx;
	logic [CELL_W-1:0]  clr_q;
	logic               build_q;
	logic [N_W-1:0]     n_q, i_q, j_q;
	logic [ENTRY_W-1:0] cur_q;
	logic               have_q;
	logic [CELL_W-1:0]  prev_q;

	// Result staging and output register.
	logic [KEY_OUT_W-1:0] res_key_q;
	logic                 res_kv_q, res_found_q;
	logic [RUN_W-1:0]     res_rs_q, res_rf_q;
	logic [VAL_W-1:0]     res_val_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                 m_tvalid_q;

	// Memories.
	logic [ENTRY_W-1:0] slot_mem [TABLE_DEPTH];
	logic [RUN_W-1:0]   start_mem [CELL_COUNT];
	logic [RUN_W-1:0]   finish_mem [CELL_COUNT];
	logic [ENTRY_W-1:0] slot_rd_q;
	logic [RUN_W-1:0]   start_rd_q, finish_rd_q;

	// Memory port controls.
	logic               sw_en;
	logic [IDX_W-1:0]   sw_addr, sr_addr;
	logic [ENTRY_W-1:0] sw_data;
	logic               cs_en, cf_en;
	logic [CELL_W-1:0]  cs_addr, cf_addr, cr_addr;
	logic [RUN_W-1:0]   cs_data, cf_data;

	// Quantizer.
	logic              q_start;
	qstat_t            q_stat;
	logic [CELL_W-1:0] q_key;

	// Derived values.
	logic                  s_acc, out_free, slot_ok, nb_ok, in_grid;
	logic [N_W-1:0]        jm1;
	logic [4:0]            nb_idx;
	logic [5:0]            ofs;
	logic signed [CIN_W:0] qx, qy, qz;
	logic [CELL_W-1:0]     q_hash;
	logic [31:0]           ec32;

	function automatic logic [CELL_W:0] rank(input logic [ENT_W-1:0] e);
		rank = e[CELL_W] ? {1'b0, e[CELL_W-1:0]} : {1'b1, {CELL_W{1'b0}}};
	endfunction

	ugch_quant #(.GRID_BITS(GRID_BITS)) u_quant (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (q_start),
		.pos_x    (pos_x_q),
		.pos_y    (pos_y_q),
		.pos_z    (pos_z_q),
		.org_x    (org_x_q),
		.org_y    (org_y_q),
		.org_z    (org_z_q),
		.inv_cell (inv_cell_q),
		.stat     (q_stat),
		.key      (q_key)
	);

	// Shared decode of the captured beat.
	always_comb begin
		s_acc    = s_tvalid && (state_q == ST_IDLE);
		out_free = !m_tvalid_q || m_tready;
		slot_ok  = (32'(slot_q) < DEPTH32);
		jm1      = j_q - N_W'(1);
		nb_ok    = (slot_q < SLOT_W'(NB_COUNT));
		nb_idx   = nb_ok ? slot_q[4:0] : 5'd0;
		ofs      = NB_OFS[nb_idx];
		qx = $signed({cx_in_q[CIN_W-1], cx_in_q}) + $signed({15'd0, ofs[1:0]}) - 17'sd1;
		qy = $signed({cy_in_q[CIN_W-1], cy_in_q}) + $signed({15'd0, ofs[3:2]}) - 17'sd1;
		qz = $signed({cz_in_q[CIN_W-1], cz_in_q}) + $signed({15'd0, ofs[5:4]}) - 17'sd1;
		in_grid = nb_ok
			&& !qx[CIN_W] && ((qx[CIN_W-1:0] >> GRID_BITS) == '0)
			&& !qy[CIN_W] && ((qy[CIN_W-1:0] >> GRID_BITS) == '0)
			&& !qz[CIN_W] && ((qz[CIN_W-1:0] >> GRID_BITS) == '0);
		q_hash = {qz[GRID_BITS-1:0], qy[GRID_BITS-1:0], qx[GRID_BITS-1:0]};
		ec32   = 32'(entry_cnt_q);
	end

	// Next state of the sequencer.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == '1) state_nx = build_q ? ST_SCAN_RD : ST_IDLE;
			ST_IDLE: if (s_acc) begin
				case (act_t'(s_tuser))
					ACT_MAP:   state_nx = ST_MAP_RUN;
					ACT_BUILD: state_nx = ST_SORT_I;
					ACT_QUERY: state_nx = ST_Q_ADDR;
					default:   state_nx = ST_R_ADDR;
				endcase
			end
			ST_MAP_RUN:   if (q_stat.done) state_nx = ST_DONE;
			ST_SORT_I:    state_nx = (i_q >= n_q) ? ST_CLEAR : ST_SORT_HOLD;
			ST_SORT_HOLD: state_nx = ST_SORT_J;
			ST_SORT_J:    state_nx = (j_q == '0) ? ST_SORT_I : ST_SORT_CMP;
			ST_SORT_CMP:  state_nx = (rank(slot_rd_q[ENT_W-1:0]) > rank(cur_q[ENT_W-1:0]))
				? ST_SORT_J : ST_SORT_I;
			ST_SCAN_RD:   state_nx = (i_q >= n_q) ? ST_SCAN_END : ST_SCAN_CHK;
			ST_SCAN_CHK:  state_nx = slot_rd_q[CELL_W] ? ST_SCAN_RD : ST_SCAN_END;
			ST_SCAN_END:  state_nx = ST_DONE;
			ST_Q_ADDR:    state_nx = in_grid ? ST_Q_DATA : ST_DONE;
			ST_Q_DATA:    state_nx = ST_DONE;
			ST_R_ADDR:    state_nx = ST_R_DATA;
			ST_R_DATA:    state_nx = ST_DONE;
			ST_DONE:      if (out_free) state_nx = ST_IDLE;
			default:      state_nx = ST_IDLE;
		endcase
	end

	// Memory port and handshake controls per state.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		q_start  = s_acc && (act_t'(s_tuser) == ACT_MAP);
		sw_en    = 1'b0;
		sw_addr  = j_q[IDX_W-1:0];
		sw_data  = cur_q;
		sr_addr  = i_q[IDX_W-1:0];
		cs_en    = 1'b0;
		cs_addr  = clr_q;
		cs_data  = RUN_EMPTY;
		cf_en    = 1'b0;
		cf_addr  = clr_q;
		cf_data  = RUN_EMPTY;
		cr_addr  = q_hash;
		case (state_q)
			ST_CLEAR: begin
				cs_en = 1'b1;
				cf_en = 1'b1;
			end
			ST_MAP_RUN: begin
				sw_en   = q_stat.done && slot_ok;
				sw_addr = IDX_W'(slot_q);
				sw_data = {val_q, q_stat.valid, q_key};
			end
			ST_SORT_J: begin
				sw_en   = (j_q == '0);
				sr_addr = jm1[IDX_W-1:0];
			end
			ST_SORT_CMP: begin
				sw_en = 1'b1;
				if (rank(slot_rd_q[ENT_W-1:0]) > rank(cur_q[ENT_W-1:0])) sw_data = slot_rd_q;
			end
			ST_SCAN_CHK: begin
				if (slot_rd_q[CELL_W] && (!have_q || slot_rd_q[CELL_W-1:0] != prev_q)) begin
					cs_en   = 1'b1;
					cs_addr = slot_rd_q[CELL_W-1:0];
					cs_data = RUN_W'(i_q);
					cf_en   = have_q;
					cf_addr = prev_q;
					cf_data = RUN_W'(i_q);
				end
			end
			ST_SCAN_END: begin
				cf_en   = have_q;
				cf_addr = prev_q;
				cf_data = RUN_W'(i_q);
			end
			ST_R_ADDR: sr_addr = IDX_W'(slot_q);
			default: ;
		endcase
	end

	// Slot table: entry is {value, key valid, key}.
	always_ff @(posedge clk) begin
		if (sw_en) slot_mem[sw_addr] <= sw_data;
		slot_rd_q <= slot_mem[sr_addr];
	end

	// Cell run tables.
	always_ff @(posedge clk) begin
		if (cs_en) start_mem[cs_addr] <= cs_data;
		start_rd_q <= start_mem[cr_addr];
	end

	always_ff @(posedge clk) begin
		if (cf_en) finish_mem[cf_addr] <= cf_data;
		finish_rd_q <= finish_mem[cr_addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q     <= '0;
			org_y_q     <= '0;
			org_z_q     <= '0;
			inv_cell_q  <= 32'h0001_0000;
			entry_cnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X:  org_x_q <= cfg_data;
				CFG_ORIGIN_Y:  org_y_q <= cfg_data;
				CFG_ORIGIN_Z:  org_z_q <= cfg_data;
				CFG_INV_CELL:  inv_cell_q <= cfg_data;
				CFG_ENTRY_CNT: entry_cnt_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			build_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + CELL_W'(1);
				ST_IDLE: build_q <= s_acc && (act_t'(s_tuser) == ACT_BUILD);
				default: ;
			endcase
			// The result register fills from the done state and empties on a taken beat.
			if ((state_q == ST_DONE) && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Beat capture, sort and scan counters, and results.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_acc) begin
				pos_x_q     <= s_tdata[31:0];
				pos_y_q     <= s_tdata[63:32];
				pos_z_q     <= s_tdata[95:64];
				val_q       <= s_tdata[115:96];
				slot_q      <= s_tdata[125:116];
				cx_in_q     <= s_tdata[141:126];
				cy_in_q     <= s_tdata[157:142];
				cz_in_q     <= s_tdata[173:158];
				res_key_q   <= '0;
				res_kv_q    <= 1'b0;
				res_rs_q    <= '0;
				res_rf_q    <= '0;
				res_found_q <= 1'b0;
				res_val_q   <= '0;
				i_q         <= N_W'(1);
				have_q      <= 1'b0;
				n_q         <= N_W'((ec32 < DEPTH32) ? ec32 : DEPTH32);
			end
			ST_MAP_RUN: if (q_stat.done) begin
				res_key_q <= KEY_OUT_W'(q_key);
				res_kv_q  <= q_stat.valid;
			end
			ST_SORT_I: if (i_q >= n_q) i_q <= '0;
			ST_SORT_HOLD: begin
				cur_q <= slot_rd_q;
				j_q   <= i_q;
			end
			ST_SORT_J: if (j_q == '0) i_q <= i_q + N_W'(1);
			ST_SORT_CMP: begin
				if (rank(slot_rd_q[ENT_W-1:0]) > rank(cur_q[ENT_W-1:0])) j_q <= jm1;
				else i_q <= i_q + N_W'(1);
			end
			ST_SCAN_CHK: if (slot_rd_q[CELL_W]) begin
				prev_q <= slot_rd_q[CELL_W-1:0];
				have_q <= 1'b1;
				i_q    <= i_q + N_W'(1);
			end
			ST_Q_ADDR: begin
				res_rs_q <= RUN_EMPTY;
				res_rf_q <= RUN_EMPTY;
			end
			ST_Q_DATA: begin
				res_rs_q    <= start_rd_q;
				res_rf_q    <= finish_rd_q;
				res_found_q <= (start_rd_q != RUN_EMPTY);
			end
			ST_R_DATA: if (slot_ok) res_val_q <= slot_rd_q[ENTRY_W-1 -: VAL_W];
			ST_DONE: if (out_free) begin
				m_tdata_q <= {4'd0, 1'b1, res_val_q, res_found_q, res_rf_q, res_rs_q,
					res_kv_q, res_key_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ugch_checker.sv =====
// Port-level checker for the uniform grid cell hash, bound to the top level.
// Depends on ugch_pkg and uniform_grid_cell_hash_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "uniform_grid_cell_hash_defines.svh"
module ugch_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [ugch_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import ugch_pkg::*;

	// A stalled result beat holds.
	`UGCH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// The block works on one beat at a time.
	`UGCH_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// Every result reports completion.
	`UGCH_ASSERT_NOW(a_done_set, clk, arst_n, m_tvalid, m_tdata[59])
	// A found run never carries the empty marker.
	`UGCH_ASSERT_NOW(a_found_run, clk, arst_n, m_tvalid && m_tdata[38], m_tdata[26:16] != RUN_EMPTY)
	// An invalid key reads as zero.
	`UGCH_ASSERT_NOW(a_key_zero, clk, arst_n, m_tvalid && !m_tdata[15], m_tdata[14:0] == 15'd0)

endmodule

bind uniform_grid_cell_hash ugch_checker u_ugch_checker (.*);
`default_nettype wire

// ===== sim/uniform_grid_cell_hash_tb.sv =====
// Self-checking testbench for the uniform grid cell hash: directed rows, a table fill with
// one full-depth build, then random phases under several register settings.
// Depends on ugch_pkg and the uniform_grid_cell_hash top level.
`timescale 1ns / 1ps
module uniform_grid_cell_hash_tb;
	import ugch_pkg::*;

	localparam int GRID_DIM = 32;
	localparam int CELLS = 32768;
	localparam int DEPTH = 1024;

	typedef struct {
		act_t              act;
		logic signed [31:0] px, py, pz;
		logic [19:0]       val;
		logic [9:0]        slot;
		logic signed [15:0] cx, cy, cz;
	} grid_item_t;

	// Packed from the top bit down, so cell_key lands in the lowest bits.
	typedef struct packed {
		logic        done;
		logic [19:0] sval;
		logic        found;
		logic [10:0] rfinish;
		logic [10:0] rstart;
		logic        kvalid;
		logic [14:0] key;
	} grid_res_t;

	typedef struct {
		grid_item_t it;
		bit         fixed;
		grid_res_t  res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [POS_W-1:0] cfg_data = '0;

	// Pacing and pressure controls.
	int unsigned send_idle = 36;
	int unsigned recv_idle = 87;
	logic recv_hold = 1'b0;
	int phase_no = 0;
	int errors = 0;

	// Predictor state.
	logic signed [31:0] org_x, org_y, org_z;
	logic [31:0] inv_cell;
	logic [10:0] used_slots;
	logic [15:0] key_mem [DEPTH];
	logic [19:0] val_mem [DEPTH];
	logic [10:0] first_slot [CELLS];
	logic [10:0] end_slot [CELLS];

	grid_res_t results_due [$];

	uniform_grid_cell_hash dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Quantize one axis; zero when the point falls outside the grid.
	function automatic bit quantize_axis(logic signed [31:0] pos, logic signed [31:0] org,
			output logic [4:0] g);
		longint q;
		logic [95:0] prod;
		q = longint'(pos) - longint'(org);
		g = '0;
		if (q < 0) return 1'b0;
		prod = 96'(q) * 96'(inv_cell);
		if ((prod >> 32) > GRID_DIM - 1) return 1'b0;
		g = prod[36:32];
		return 1'b1;
	endfunction

	function automatic int sort_rank(logic [15:0] k);
		return k[15] ? int'(k[14:0]) : CELLS;
	endfunction

	// Stable sort of the used slots, then rebuild the cell run tables.
	function automatic void rebuild_runs();
		int n, j, prev;
		bit have_prev;
		logic [15:0] k;
		logic [19:0] v;
		n = (used_slots < DEPTH) ? used_slots : DEPTH;
		for (int i = 1; i < n; i++) begin
			k = key_mem[i];
			v = val_mem[i];
			j = i;
			while (j > 0 && sort_rank(key_mem[j-1]) > sort_rank(k)) begin
				key_mem[j] = key_mem[j-1];
				val_mem[j] = val_mem[j-1];
				j--;
			end
			key_mem[j] = k;
			val_mem[j] = v;
		end
		for (int c = 0; c < CELLS; c++) begin
			first_slot[c] = RUN_EMPTY;
			end_slot[c] = RUN_EMPTY;
		end
		have_prev = 0;
		prev = 0;
		j = 0;
		for (j = 0; j < n; j++) begin
			if (!key_mem[j][15]) break;
			if (!have_prev || int'(key_mem[j][14:0]) != prev) begin
				if (have_prev) end_slot[prev] = 11'(j);
				prev = key_mem[j][14:0];
				have_prev = 1;
				first_slot[prev] = 11'(j);
			end
		end
		if (have_prev) end_slot[prev] = 11'(j);
	endfunction

	// Expected result of one accepted beat; updates the predictor state.
	function automatic grid_res_t hash_predict(grid_item_t it);
		grid_res_t r;
		logic [4:0] gx, gy, gz;
		bit ok;
		int nx, ny, nz;
		r = '0;
		r.done = 1'b1;
		case (it.act)
			ACT_MAP: begin
				ok = quantize_axis(it.px, org_x, gx);
				ok = quantize_axis(it.py, org_y, gy) && ok;
				ok = quantize_axis(it.pz, org_z, gz) && ok;
				r.key = ok ? {gz, gy, gx} : '0;
				r.kvalid = ok;
				key_mem[it.slot] = ok ? {1'b1, gz, gy, gx} : '0;
				val_mem[it.slot] = it.val;
			end
			ACT_BUILD: rebuild_runs();
			ACT_QUERY: begin
				r.rstart = RUN_EMPTY;
				r.rfinish = RUN_EMPTY;
				if (it.slot < NB_COUNT) begin
					nx = int'(it.cx) + int'(it.slot) % 3 - 1;
					ny = int'(it.cy) + (int'(it.slot) / 3) % 3 - 1;
					nz = int'(it.cz) + int'(it.slot) / 9 - 1;
					if (nx >= 0 && nx < GRID_DIM && ny >= 0 && ny < GRID_DIM &&
							nz >= 0 && nz < GRID_DIM) begin
						r.rstart = first_slot[nz * 1024 + ny * 32 + nx];
						r.rfinish = end_slot[nz * 1024 + ny * 32 + nx];
						r.found = (r.rstart != RUN_EMPTY);
					end
				end
			end
			default: r.sval = val_mem[it.slot];
		endcase
		return r;
	endfunction

	function automatic grid_item_t mk_item(act_t a, logic signed [31:0] px, py, pz,
			logic [19:0] v, logic [9:0] s, logic signed [15:0] cx, cy, cz);
		grid_item_t it;
		it.act = a; it.px = px; it.py = py; it.pz = pz; it.val = v; it.slot = s;
		it.cx = cx; it.cy = cy; it.cz = cz;
		return it;
	endfunction

	function automatic grid_res_t mk_res(logic [14:0] k, logic kv, logic [10:0] rs, rf,
			logic fd, logic [19:0] v);
		grid_res_t r;
		r.key = k; r.kvalid = kv; r.rstart = rs; r.rfinish = rf; r.found = fd;
		r.sval = v; r.done = 1'b1;
		return r;
	endfunction

	// Drive one beat, wait for acceptance, queue its expectation.
	task automatic send_beat(grid_item_t it, bit fixed, grid_res_t fixed_res);
		grid_res_t r;
		s_tdata <= {2'b00, it.cz, it.cy, it.cx, it.slot, it.val, it.pz, it.py, it.px};
		s_tuser <= it.act;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = hash_predict(it);
		results_due.push_back(fixed ? fixed_res : r);
		while ($urandom % 100 < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Lower valid and wait until every expected result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the caller lowers the write enable after the last one.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_ORIGIN_X: org_x = data;
			CFG_ORIGIN_Y: org_y = data;
			CFG_ORIGIN_Z: org_z = data;
			CFG_INV_CELL: inv_cell = data;
			default: used_slots = data[10:0];
		endcase
	endtask

	task automatic set_regs(logic [31:0] ox, oy, oz, inv, logic [10:0] cnt);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_INV_CELL, inv);
		write_reg(CFG_ENTRY_CNT, {21'd0, cnt});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A position that mostly lands inside the grid for the current origin and scale.
	function automatic logic signed [31:0] grid_pos(logic signed [31:0] org);
		longint span, p;
		if ($urandom % 100 < 15) return $urandom;
		span = (inv_cell == 0) ? 64'h1_0000_0000 : ((64'd32 << 32) - 1) / inv_cell;
		if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
		p = longint'(org) + ({$urandom, $urandom} % (span + 1));
		if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
		return p[31:0];
	endfunction

	function automatic logic signed [15:0] near_cell();
		return ($urandom % 100 < 10) ? 16'($urandom) : 16'($urandom_range(0, 33)) - 16'sd1;
	endfunction

	function automatic grid_item_t random_item();
		grid_item_t it;
		int pick;
		it = mk_item(ACT_READ, $urandom, $urandom, $urandom, 20'($urandom), 10'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom));
		pick = $urandom % 100;
		if (pick < 35) begin
			it.act = ACT_MAP;
			if ($urandom % 100 < 70) it.slot = 10'($urandom_range(0, 63));
			it.px = grid_pos(org_x);
			it.py = grid_pos(org_y);
			it.pz = grid_pos(org_z);
		end else if (pick < 37) begin
			it.act = ACT_BUILD;
		end else if (pick < 70) begin
			it.act = ACT_QUERY;
			if ($urandom % 100 < 85) it.slot = 10'($urandom % NB_COUNT);
			it.cx = near_cell();
			it.cy = near_cell();
			it.cz = near_cell();
		end else if ($urandom % 100 < 70) begin
			it.slot = 10'($urandom_range(0, 63));
		end
		return it;
	endfunction

	// Receiver: check each result beat, then decide readiness for the next edge.
	always @(posedge clk) begin
		grid_res_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[59:0];
			if (results_due.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, got);
				errors++;
			end else begin
				want = results_due.pop_front();
				if (got.key !== want.key || got.kvalid !== want.kvalid) begin
					$display("%0t: cell_key/key_valid expected %h/%b actual %h/%b", $time,
						want.key, want.kvalid, got.key, got.kvalid);
					errors++;
				end
				if (got.rstart !== want.rstart || got.rfinish !== want.rfinish ||
						got.found !== want.found) begin
					$display("%0t: range expected %0d..%0d found %b actual %0d..%0d found %b",
						$time, want.rstart, want.rfinish, want.found,
						got.rstart, got.rfinish, got.found);
					errors++;
				end
				if (got.sval !== want.sval || got.done !== want.done) begin
					$display("%0t: stored_value/done expected %h/%b actual %h/%b", $time,
						want.sval, want.done, got.sval, got.done);
					errors++;
				end
			end
		end
		m_tready <= arst_n && !recv_hold && ($urandom % 100 >= recv_idle);
	end

	// Long receiver hold-off while the sender keeps offering beats.
	initial begin
		wait (phase_no == 2);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (400) @(posedge clk);
		recv_hold <= 1'b0;
	end

	// Run limit.
	initial begin
		#(64'd60_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus.
	initial begin
		dir_row_t rows [$];
		dir_row_t row;
		grid_res_t miss;
		int limit;
		org_x = 0; org_y = 0; org_z = 0; inv_cell = 32'd65536; used_slots = 0;
		for (int c = 0; c < CELLS; c++) begin
			first_slot[c] = RUN_EMPTY;
			end_slot[c] = RUN_EMPTY;
		end
		miss = mk_res(0, 0, RUN_EMPTY, RUN_EMPTY, 0, 0);

		// Directed rows; fixed expectations where they are obvious.
		rows.push_back('{mk_item(ACT_QUERY, 0, 0, 0, 0, 13, 0, 0, 0), 1, miss});
		rows.push_back('{mk_item(ACT_MAP, 0, 0, 0, 20'hFFFFF, 0, 0, 0, 0), 1,
			mk_res(0, 1, 0, 0, 0, 0)});
		rows.push_back('{mk_item(ACT_MAP, 32'h1F_FFFF, 32'h1F_FFFF, 32'h1F_FFFF, 0, 1023,
			16'hFFFF, 16'hFFFF, 16'hFFFF), 1, mk_res(15'h7FFF, 1, 0, 0, 0, 0)});
		rows.push_back('{mk_item(ACT_MAP, 32'h20_0000, 0, 0, 5, 2, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(ACT_MAP, -1, 0, 0, 6, 3, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(ACT_MAP, 32'h8000_0000, 32'h7FFF_FFFF, 0, 7, 4, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(ACT_MAP, 32'h5_8000, 32'h7_0000, 32'h9_FFFF, 20'h12345, 5,
			0, 0, 0), 0, miss});
		rows.push_back('{mk_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 20'hFFFFF)});
		rows.push_back('{mk_item(ACT_READ, 0, 0, 0, 0, 1023, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(ACT_READ, 0, 0, 0, 0, 5, 0, 0, 0), 0, miss});
		rows.push_back('{mk_item(ACT_BUILD, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0)});
		rows.push_back('{mk_item(ACT_QUERY, 0, 0, 0, 0, 27, 0, 0, 0), 1, miss});
		rows.push_back('{mk_item(ACT_QUERY, 0, 0, 0, 0, 1023, 1, 1, 1), 1, miss});
		rows.push_back('{mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000),
			1, miss});
		rows.push_back('{mk_item(ACT_QUERY, 0, 0, 0, 0, 26, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF),
			1, miss});
		rows.push_back('{mk_item(ACT_QUERY, 0, 0, 0, 0, 0, 1, 1, 1), 0, miss});
		rows.push_back('{mk_item(ACT_QUERY, 0, 0, 0, 0, 26, 30, 30, 30), 0, miss});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			send_beat(row.it, row.fixed, row.res);
		end
		drain();

		// Fill every slot with keys already in order, invalid ones at the tail.
		set_regs(0, 0, 0, 32'd65536, 11'd1024);
		for (int i = 0; i < DEPTH; i++)
			send_beat(mk_item(ACT_MAP,
				(i < 1000) ? {11'd0, 5'(i % 32), 16'($urandom)} : -32'sd1,
				{11'd0, 5'(i / 32), 16'($urandom)}, {16'd0, 16'($urandom)},
				20'($urandom), 10'(i), 0, 0, 0), 0, miss);
		send_beat(mk_item(ACT_BUILD, 0, 0, 0, 0, 0, 0, 0, 0), 0, miss);
		for (int i = 0; i < 10; i++)
			send_beat(random_item(), 0, miss);
		drain();

		// Random phases under different settings and pacing.
		for (int p = 0; p < 4; p++) begin
			phase_no = p + 1;
			case (p)
				0: set_regs(32'($urandom_range(0, 2 ** 21)) - 32'd1048576, $urandom, 32'd0,
					32'd131072, 11'd48);
				1: set_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
					11'd1);
				2: set_regs(32'h7FFF_FFFF, 0, 0, 32'd0, 11'd64);
				default: set_regs(0, 0, 0, 32'd65536, 11'd200);
			endcase
			if (p == 1) begin
				send_idle = 87;
				recv_idle = 36;
			end else if (p == 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			limit = (p == 2) ? 20 : 25;
			for (int i = 0; i < limit; i++) begin
				send_beat(random_item(), 0, miss);
				if ($urandom % 100 == 0) drain();
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ugch_pkg.sv
hw/rtl/ugch_quant.sv
hw/rtl/uniform_grid_cell_hash.sv
hw/rtl/ugch_checker.sv
sim/uniform_grid_cell_hash_tb.sv
